@@ rtl/dfa_pkg.sv @@
`default_nettype none

package dfa_pkg;

  localparam int STATE_W = 4;
  localparam int SYM_W   = 8;
  localparam int NUM_W   = 5;
  localparam logic [SYM_W-1:0] FORBIDDEN_SYM = 8'h26;  // '&'

  typedef enum logic [2:0] {
    OP_ADD_SYM   = 3'd0,
    OP_SET_ACC   = 3'd1,
    OP_ADD_TRANS = 3'd2,
    OP_STR_SYM   = 3'd3,
    OP_EMPTY     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SYM  = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FORBID  = 2'd3
  } status_t;

  typedef enum logic {
    CFG_START_STATE = 1'b0,
    CFG_NUM_STATES  = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CLR_SWEEP,
    CLR_DONE
  } clr_state_t;

endpackage

`default_nettype wire

@@ rtl/dfa_ram.sv @@
`default_nettype none

module dfa_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/dfa_clear.sv @@
`default_nettype none

module dfa_clear #(
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  output logic                          clr_busy,
  output logic      [$clog2(DEPTH)-1:0] clr_addr
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  dfa_pkg::clr_state_t state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dfa_pkg::CLR_SWEEP: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = dfa_pkg::CLR_DONE;
        end
      end
      dfa_pkg::CLR_DONE: begin
        state_nxt = dfa_pkg::CLR_DONE;
      end
    endcase
  end

  always_comb begin
    clr_busy = 1'b0;
    addr_nxt = addr_r;
    unique case (state_r)
      dfa_pkg::CLR_SWEEP: begin
        clr_busy = 1'b1;
        addr_nxt = addr_r + AW'(1);
      end
      dfa_pkg::CLR_DONE: begin
        clr_busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfa_pkg::CLR_SWEEP;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  assign clr_addr = addr_r;

endmodule

`default_nettype wire

@@ rtl/dfa_string_acceptor_core.sv @@
// Results: every accepted item gives one result strobe (out_valid) in the cycle after it
//   is accepted; the receiver cannot stall.
// Throughput: one item per cycle while busy is low; an add-transition holds busy while
//   its alphabet read resolves and the transition memory is written.
// Reset: synchronous, active low; stores clear, state count to 16. Both memories are then
//   swept together, one entry a cycle, over STATE_COUNT' * 2^SYMBOL_BITS addresses (4096
//   at the defaults, STATE_COUNT' = min(STATE_COUNT, 16)); busy is high, no item taken.
`default_nettype none

module dfa_string_acceptor_core #(
  parameter int STATE_COUNT = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // item channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_opcode,
  input  wire logic [dfa_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic [dfa_pkg::STATE_W-1:0]   in_from_state,
  input  wire logic [dfa_pkg::STATE_W-1:0]   in_to_state,
  input  wire logic                          in_accepting,
  input  wire logic                          in_last,
  // result channel
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic                               out_verdict_valid,
  output logic                               out_accepted,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [dfa_pkg::NUM_W-1:0]     cfg_data
);

  localparam int SW       = dfa_pkg::STATE_W;
  // Only 16 state numbers can be named by the fields, so rows beyond that never fill.
  localparam int ROWS     = (STATE_COUNT < 16) ? STATE_COUNT : 16;
  localparam int ROW_BITS = $clog2(ROWS);
  localparam int SYM_CNT  = 1 << SYMBOL_BITS;
  localparam int DEPTH    = ROWS * SYM_CNT;
  localparam int AW       = $clog2(DEPTH);
  localparam int WW       = SW + 1;  // valid bit plus destination

  function automatic logic acc_of(input logic [ROWS-1:0] bits, input logic [SW-1:0] s);
    acc_of = (32'(s) < STATE_COUNT) && bits[s[ROW_BITS-1:0]];
  endfunction

  // ---------------------------------------------------------------------------
  // Stores held in flops: config, accepting bits, walk state
  // ---------------------------------------------------------------------------
  logic [SW-1:0]               start_r, start_nxt;
  logic [dfa_pkg::NUM_W-1:0]   nstates_r, nstates_nxt;
  logic [ROWS-1:0]             acc_r, acc_nxt;
  logic [SW-1:0]               cur_r, cur_nxt;
  logic                        dead_r, dead_nxt;
  logic                        in_str_r, in_str_nxt;

  // Result stage: one beat in flight, resolved against the memory read data
  logic                        p_valid_r, p_valid_nxt;
  logic                        p_str_r, p_str_nxt;      // pending string symbol
  logic                        p_last_r, p_last_nxt;
  logic                        p_lookup_r, p_lookup_nxt;
  logic [SW-1:0]               p_state_r, p_state_nxt;
  logic [1:0]                  p_status_r, p_status_nxt;
  logic                        p_vv_r, p_vv_nxt;
  logic                        p_acc_r, p_acc_nxt;      // verdict of an empty string
  // Pending add-transition: in range, waiting on the alphabet read
  logic                        p_trans_r, p_trans_nxt;
  logic [SW-1:0]               p_from_r, p_from_nxt;
  logic [SW-1:0]               p_to_r, p_to_nxt;
  logic [SYMBOL_BITS-1:0]      p_sym_r, p_sym_nxt;

  // ---------------------------------------------------------------------------
  // Transition and alphabet memories and their clearing sweep
  // ---------------------------------------------------------------------------
  logic                   clr_busy;
  logic [AW-1:0]          clr_addr;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [WW-1:0]          ram_rdata;
  logic                   alpha_we;
  logic [SYMBOL_BITS-1:0] alpha_waddr;
  logic                   alpha_wdata;
  logic                   alpha_rdata;

  dfa_clear #(
    .DEPTH (DEPTH)
  ) u_clear (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy),
    .clr_addr (clr_addr)
  );

  dfa_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dfa_ram #(
    .WIDTH (1),
    .DEPTH (SYM_CNT)
  ) u_alpha_ram (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (alpha_waddr),
    .wdata (alpha_wdata),
    .raddr (in_symbol[SYMBOL_BITS-1:0]),
    .rdata (alpha_rdata)
  );

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic         accept;
  dfa_pkg::op_t op;

  // Hold off beats while the sweep runs or an add-transition resolves and writes.
  assign busy      = clr_busy || p_trans_r;
  assign accept    = start && !busy;
  assign op        = dfa_pkg::op_t'(in_opcode);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Resolve the pending string symbol from the memory read data. The walk state
  // seen by the next beat is forwarded from here, so symbols can go back to back.
  // ---------------------------------------------------------------------------
  logic          res_hit;
  logic [SW-1:0] res_state;
  logic          res_dead;
  logic [SW-1:0] eff_cur;
  logic          eff_dead;

  assign res_hit   = p_lookup_r && ram_rdata[SW];
  assign res_state = res_hit ? ram_rdata[SW-1:0] : p_state_r;
  assign res_dead  = !res_hit;
  assign eff_cur   = p_str_r ? res_state : cur_r;
  assign eff_dead  = p_str_r ? res_dead : dead_r;

  // The first symbol of a string starts over from the start state.
  logic [SW-1:0] base_state;
  logic          base_dead;
  logic          sym_fits;
  logic          lookup;
  logic          from_ok;
  logic          to_ok;

  assign base_state   = in_str_r ? eff_cur : start_r;
  assign base_dead    = in_str_r && eff_dead;
  assign sym_fits     = 32'(in_symbol) < SYM_CNT;
  // A transition is only ever stored for an alphabet symbol, and the alphabet never
  // shrinks, so the table entry alone decides the step.
  assign lookup       = !base_dead && sym_fits && (32'(base_state) < STATE_COUNT);
  assign from_ok      = ({1'b0, in_from_state} < nstates_r) &&
                        (32'(in_from_state) < STATE_COUNT);
  assign to_ok        = ({1'b0, in_to_state} < nstates_r) &&
                        (32'(in_to_state) < STATE_COUNT);

  assign ram_raddr = {base_state[ROW_BITS-1:0], in_symbol[SYMBOL_BITS-1:0]};

  // Memory writes: the clearing sweep owns both ports while it runs. A pending
  // add-transition writes in the cycle after its beat, once the alphabet is read.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {p_from_r[ROW_BITS-1:0], p_sym_r};
    ram_wdata = {1'b1, p_to_r};
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (p_trans_r && alpha_rdata) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    alpha_we    = 1'b0;
    alpha_waddr = in_symbol[SYMBOL_BITS-1:0];
    alpha_wdata = 1'b1;
    if (clr_busy) begin
      alpha_we    = 1'b1;
      alpha_waddr = clr_addr[SYMBOL_BITS-1:0];
      alpha_wdata = 1'b0;
    end else if (accept && op == dfa_pkg::OP_ADD_SYM && sym_fits &&
                 in_symbol != dfa_pkg::FORBIDDEN_SYM) begin
      alpha_we = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Next-state logic for the stores and the result stage
  // ---------------------------------------------------------------------------
  always_comb begin
    start_nxt    = start_r;
    nstates_nxt  = nstates_r;
    acc_nxt      = acc_r;
    cur_nxt      = cur_r;
    dead_nxt     = dead_r;
    in_str_nxt   = in_str_r;

    p_valid_nxt  = accept;
    p_str_nxt    = 1'b0;
    p_last_nxt   = in_last;
    p_lookup_nxt = lookup;
    p_state_nxt  = base_state;
    p_status_nxt = dfa_pkg::ST_OK;
    p_vv_nxt     = 1'b0;
    p_acc_nxt    = 1'b0;
    p_trans_nxt  = 1'b0;
    p_from_nxt   = in_from_state;
    p_to_nxt     = in_to_state;
    p_sym_nxt    = in_symbol[SYMBOL_BITS-1:0];

    if (cfg_valid && cfg_ready) begin
      unique case (dfa_pkg::cfg_idx_t'(cfg_index))
        dfa_pkg::CFG_START_STATE: start_nxt   = cfg_data[SW-1:0];
        dfa_pkg::CFG_NUM_STATES:  nstates_nxt = cfg_data;
      endcase
    end

    // Commit the symbol looked up in the previous beat.
    if (p_str_r) begin
      cur_nxt  = res_state;
      dead_nxt = res_dead;
    end

    // A newly accepted beat wins over the commit.
    if (accept) begin
      unique case (op)
        dfa_pkg::OP_ADD_SYM: begin
          // the alphabet write itself goes to memory
          if (!sym_fits) begin
            p_status_nxt = dfa_pkg::ST_NO_SYM;
          end else if (in_symbol == dfa_pkg::FORBIDDEN_SYM) begin
            p_status_nxt = dfa_pkg::ST_FORBID;
          end
        end
        dfa_pkg::OP_SET_ACC: begin
          if (!from_ok) begin
            p_status_nxt = dfa_pkg::ST_RANGE;
          end else if (in_accepting) begin
            acc_nxt[in_from_state[ROW_BITS-1:0]] = 1'b1;
          end
        end
        dfa_pkg::OP_ADD_TRANS: begin
          // range test first; the alphabet test resolves on the next cycle
          if (!from_ok || !to_ok) begin
            p_status_nxt = dfa_pkg::ST_RANGE;
          end else if (!sym_fits) begin
            p_status_nxt = dfa_pkg::ST_NO_SYM;
          end else begin
            p_trans_nxt = 1'b1;
          end
        end
        dfa_pkg::OP_STR_SYM: begin
          p_str_nxt  = 1'b1;
          p_vv_nxt   = in_last;
          cur_nxt    = base_state;
          dead_nxt   = !lookup;
          in_str_nxt = !in_last;
        end
        dfa_pkg::OP_EMPTY: begin
          cur_nxt    = start_r;
          dead_nxt   = 1'b0;
          in_str_nxt = 1'b0;
          p_vv_nxt   = 1'b1;
          p_acc_nxt  = acc_of(acc_r, start_r);
        end
        default: begin
          // unused opcodes: plain ok beat, no verdict
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= '0;
      nstates_r  <= dfa_pkg::NUM_W'(16);
      acc_r      <= '0;
      cur_r      <= '0;
      dead_r     <= 1'b0;
      in_str_r   <= 1'b0;
      p_valid_r  <= 1'b0;
      p_str_r    <= 1'b0;
      p_last_r   <= 1'b0;
      p_lookup_r <= 1'b0;
      p_state_r  <= '0;
      p_status_r <= dfa_pkg::ST_OK;
      p_vv_r     <= 1'b0;
      p_acc_r    <= 1'b0;
      p_trans_r  <= 1'b0;
      p_from_r   <= '0;
      p_to_r     <= '0;
      p_sym_r    <= '0;
    end else begin
      start_r    <= start_nxt;
      nstates_r  <= nstates_nxt;
      acc_r      <= acc_nxt;
      cur_r      <= cur_nxt;
      dead_r     <= dead_nxt;
      in_str_r   <= in_str_nxt;
      p_valid_r  <= p_valid_nxt;
      p_str_r    <= p_str_nxt;
      p_last_r   <= p_last_nxt;
      p_lookup_r <= p_lookup_nxt;
      p_state_r  <= p_state_nxt;
      p_status_r <= p_status_nxt;
      p_vv_r     <= p_vv_nxt;
      p_acc_r    <= p_acc_nxt;
      p_trans_r  <= p_trans_nxt;
      p_from_r   <= p_from_nxt;
      p_to_r     <= p_to_nxt;
      p_sym_r    <= p_sym_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result beat: the verdict of a last symbol is taken straight off the memory;
  // an add-transition refused by the alphabet reports it here.
  // ---------------------------------------------------------------------------
  assign out_valid         = p_valid_r;
  assign out_status        = (p_trans_r && !alpha_rdata) ? dfa_pkg::ST_NO_SYM : p_status_r;
  assign out_verdict_valid = p_vv_r;
  assign out_accepted      = p_str_r ? (p_last_r && res_hit && acc_of(acc_r, res_state))
                                     : p_acc_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat gave no result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result without an accepted beat");

  a_verdict_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_verdict_valid || out_status == dfa_pkg::ST_OK) && (out_verdict_valid || !out_accepted))
    else $error("verdict fields inconsistent");

  a_string_open: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == dfa_pkg::OP_STR_SYM && !in_last) |=> in_str_r)
    else $error("string not held open after a middle symbol");

  a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |=> !out_valid)
    else $error("result during the clearing sweep");

endmodule

`default_nettype wire
